>>> sv/octave_perlin_noise_sampler_core_defines.svh
// assertion macros for the octave perlin noise sampler
`ifndef OCTAVE_PERLIN_NOISE_SAMPLER_CORE_DEFINES_SVH
`define OCTAVE_PERLIN_NOISE_SAMPLER_CORE_DEFINES_SVH
// implication checked every cycle outside reset
`define OPN_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("opn check failed");
// next-cycle implication
`define OPN_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("opn check failed");
`endif

>>> sv/opns_pkg.sv
package opns_pkg;
  localparam int HalfSizeDefault   = 256;
  localparam int MaxOctavesDefault = 8;
  localparam int FracBitsDefault   = 16;
  localparam int CoordWidth = 29;
  localparam int OutWidth   = 19;
  localparam int IndexWidth = 9;
  localparam int ValueWidth = 8;
  localparam int OctWidth   = 4;
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // 4-bit hash gradient select bits
  typedef struct packed {
    logic use_y_u;
    logic v_is_y;
    logic v_is_x;
    logic neg_u;
    logic neg_v;
  } grad_sel_t;

  function automatic grad_sel_t grad_decode(input logic [3:0] h);
    grad_sel_t g;
    g.use_y_u = h[3];
    g.v_is_y  = (h < 4'd4);
    g.v_is_x  = (h == 4'd12) || (h == 4'd14);
    g.neg_u   = h[0];
    g.neg_v   = h[1];
    return g;
  endfunction
endpackage

>>> sv/opns_table.sv
module opns_table #(
  parameter int Depth = 512,
  parameter int AddrWidth = 9,
  parameter int DataWidth = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrWidth-1:0] addr,
  input  logic [DataWidth-1:0] wdata,
  output logic [DataWidth-1:0] rdata
);
  logic [DataWidth-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/opns_mul.sv
// registered signed multiply
module opns_mul #(
  parameter int AW = 18,
  parameter int BW = 18
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

>>> sv/octave_perlin_noise_sampler_core.sv
// octave perlin noise sampler: a load request never raises busy
// a sample request runs count octaves before its result, count being
// the octave count capped at MAX_OCTAVES; each octave is fade, hash and lerp steps plus
// setup and accumulate, paced by the single-port table and the shared multiplier
// the next request is taken on the edge that ends the result cycle; the receiver cannot stall
// rst clears control and sets octave_count to 8; the table is undefined until loaded
module octave_perlin_noise_sampler_core #(
  parameter int HALF_SIZE   = opns_pkg::HalfSizeDefault,
  parameter int MAX_OCTAVES = opns_pkg::MaxOctavesDefault,
  parameter int FRAC_BITS   = opns_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [0:0] operation,
  input  logic [opns_pkg::IndexWidth-1:0] table_index,
  input  logic [opns_pkg::ValueWidth-1:0] table_value,
  input  logic signed [opns_pkg::CoordWidth-1:0] x_coord,
  input  logic signed [opns_pkg::CoordWidth-1:0] y_coord,
  input  logic signed [opns_pkg::CoordWidth-1:0] z_coord,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [opns_pkg::OctWidth-1:0] cfg_data,
  output logic done,
  output logic signed [opns_pkg::OutWidth-1:0] noise_sum,
  output logic signed [opns_pkg::OutWidth-1:0] noise_mapped
);
  import opns_pkg::*;

  localparam int Depth = 2 * HALF_SIZE;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(HALF_SIZE);
  localparam int FW    = FRAC_BITS;
  // coordinate grows by up to MAX_OCTAVES-1 bits
  localparam int XW    = CoordWidth + MAX_OCTAVES;
  localparam int OW    = $clog2(MAX_OCTAVES + 1);
  // multiplier operands: fraction/fade up to FW+2 signed, values FW+4 signed
  localparam int MA    = FW + 3;
  localparam int MB    = FW + 5;
  localparam int VW    = FW + 4;
  localparam int ACCW  = VW + MAX_OCTAVES + 2;
  localparam int SH    = MAX_OCTAVES - 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_FADE  = 7'b0000100,
    S_HASH  = 7'b0001000,
    S_LERP  = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [OctWidth-1:0] octave_count;
  logic [OW-1:0] oct, noct;
  logic signed [XW-1:0] cx, cy, cz;
  logic [CW-1:0] lx, ly, lz;
  logic [FW-1:0] fx, fy, fz;
  logic [FW:0] fu, fv, fw;
  logic [4:0] step;          // sequence step within a phase
  logic signed [ACCW-1:0] acc;

  // table port
  logic          t_we;
  logic [AW-1:0] t_addr;
  logic [ValueWidth-1:0] t_rdata;

  opns_table #(.Depth(Depth), .AddrWidth(AW), .DataWidth(ValueWidth)) u_table (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(table_value), .rdata(t_rdata)
  );

  // shared multiplier
  logic signed [MA-1:0] m_a;
  logic signed [MB-1:0] m_b;
  logic signed [MA+MB-1:0] m_p;
  opns_mul #(.AW(MA), .BW(MB)) u_mul (.clk(clk), .a(m_a), .b(m_b), .p(m_p));

  // hash registers
  logic [AW-1:0] ha, hb, haa, hab, hba, hbb;
  logic [3:0] hash [8];
  // gradients and lerp values
  logic signed [VW-1:0] gv [8];
  logic signed [VW-1:0] lv [7];
  // fade scratch
  logic [FW+1:0] f2, f3;
  logic [FW+3:0] pp;
  logic [1:0] fsel;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // rounding right shift of a product by FW, half up
  function automatic logic signed [MA+MB-1:0] rnd(input logic signed [MA+MB-1:0] v);
    logic signed [MA+MB-1:0] t;
    t = v + ($signed({{(MA+MB-1){1'b0}}, 1'b1}) <<< (FW - 1));
    return t >>> FW;
  endfunction

  function automatic logic [FW-1:0] frac_of(input logic signed [XW-1:0] c);
    return c[FW-1:0];
  endfunction

  function automatic logic [FW:0] pick_f(input logic [1:0] s, input logic [FW-1:0] a,
                                         input logic [FW-1:0] b, input logic [FW-1:0] c);
    logic [FW-1:0] r;
    case (s)
      2'd0: r = a;
      2'd1: r = b;
      default: r = c;
    endcase
    return {1'b0, r};
  endfunction

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
      input logic signed [VW-1:0] dx, input logic signed [VW-1:0] dy,
      input logic signed [VW-1:0] dz);
    grad_sel_t g;
    logic signed [VW-1:0] u, v;
    g = grad_decode(h);
    u = g.use_y_u ? dy : dx;
    v = g.v_is_y ? dy : (g.v_is_x ? dx : dz);
    return (g.neg_u ? -u : u) + (g.neg_v ? -v : v);
  endfunction

  logic signed [VW-1:0] dx0, dx1, dy0, dy1, dz0, dz1;
  assign dx0 = $signed({{(VW-FW){1'b0}}, fx});
  assign dy0 = $signed({{(VW-FW){1'b0}}, fy});
  assign dz0 = $signed({{(VW-FW){1'b0}}, fz});
  assign dx1 = dx0 - ($signed({{(VW-1){1'b0}}, 1'b1}) <<< FW);
  assign dy1 = dy0 - ($signed({{(VW-1){1'b0}}, 1'b1}) <<< FW);
  assign dz1 = dz0 - ($signed({{(VW-1){1'b0}}, 1'b1}) <<< FW);

  // hash read sequence: address per step, data lands in the following step
  logic [AW-1:0] hash_addr;
  always_comb begin
    case (step)
      5'd0:  hash_addr = AW'(lx);
      5'd1:  hash_addr = AW'(lx) + AW'(1);
      5'd2:  hash_addr = ha;
      5'd3:  hash_addr = ha + AW'(1);
      5'd4:  hash_addr = hb;
      5'd5:  hash_addr = hb + AW'(1);
      5'd6:  hash_addr = haa;
      5'd7:  hash_addr = hba;
      5'd8:  hash_addr = hab;
      5'd9:  hash_addr = hbb;
      5'd10: hash_addr = haa + AW'(1);
      5'd11: hash_addr = hba + AW'(1);
      5'd12: hash_addr = hab + AW'(1);
      5'd13: hash_addr = hbb + AW'(1);
      default: hash_addr = '0;
    endcase
  end

  always_comb begin
    t_we   = (state == S_IDLE) && start && (operation == OP_LOAD);
    t_addr = (state == S_HASH) ? hash_addr : table_index[AW-1:0];
  end

  // lerp schedule: index of lerp (0..6), operands t, a, b
  // 0: u,g0,g1 1: u,g2,g3 2: u,g4,g5 3: u,g6,g7 4: v,l0,l1 5: v,l2,l3 6: w,l4,l5
  logic [2:0] li;
  logic [1:0] lph;
  logic signed [VW-1:0] la, lb;
  logic [FW:0] lt;
  always_comb begin
    case (li)
      3'd0: begin la = gv[0]; lb = gv[1]; lt = fu; end
      3'd1: begin la = gv[2]; lb = gv[3]; lt = fu; end
      3'd2: begin la = gv[4]; lb = gv[5]; lt = fu; end
      3'd3: begin la = gv[6]; lb = gv[7]; lt = fu; end
      3'd4: begin la = lv[0]; lb = lv[1]; lt = fv; end
      3'd5: begin la = lv[2]; lb = lv[3]; lt = fv; end
      default: begin la = lv[4]; lb = lv[5]; lt = fw; end
    endcase
  end

  // fade micro-steps per coordinate: 0 f*f, 1 f2*f, 2 p=6f^2-15f+10 (via f*(6f-15one)), 3 f3*p
  logic [FW:0] ff;
  logic signed [MA+MB-1:0] r_now;
  logic signed [MB-1:0] pterm;
  assign ff    = pick_f(fsel, fx, fy, fz);
  assign r_now = rnd(m_p);
  assign pterm = $signed(MB'(6) * $signed({1'b0, ff}))
               - $signed(MB'(15) <<< FW);

  always_comb begin
    m_a = '0;
    m_b = '0;
    if (state == S_FADE) begin
      case (step[2:0])
        3'd0: begin m_a = $signed(MA'(ff)); m_b = $signed(MB'(ff)); end
        3'd2: begin m_a = $signed(MA'(f2)); m_b = $signed(MB'(ff)); end
        3'd4: begin m_a = $signed(MA'(ff)); m_b = pterm; end
        3'd6: begin m_a = $signed(MA'(f3)); m_b = $signed(MB'(pp)); end
        default: ;
      endcase
    end else if (state == S_LERP) begin
      m_a = $signed(MA'(lt));
      m_b = MB'(lb) - MB'(la);
    end
  end

  // octave-weighted octave value and saturated outputs
  logic signed [ACCW-1:0] add_term;
  logic signed [ACCW+1:0] os, om;
  logic signed [ACCW+1:0] rb;
  assign add_term = ACCW'(lv[6]) <<< (SH - int'(oct));
  assign rb = $signed({{(ACCW+1){1'b0}}, 1'b1});

  function automatic logic signed [OutWidth-1:0] sat(input logic signed [ACCW+1:0] v);
    logic signed [ACCW+1:0] mx, mn;
    mx = (rb <<< (OutWidth - 1)) - rb;
    mn = -(rb <<< (OutWidth - 1));
    if (v > mx) return OutWidth'(mx);
    if (v < mn) return OutWidth'(mn);
    return v[OutWidth-1:0];
  endfunction

  always_comb begin
    os = (ACCW+2)'(acc) + ((SH > 0) ? (rb <<< (SH > 0 ? SH - 1 : 0)) : '0);
    os = os >>> SH;
    om = (ACCW+2)'(acc) + (rb <<< (FW + SH)) + (rb <<< SH);
    om = om >>> (SH + 1);
  end

  logic [FW+1:0] fade_cap;
  always_comb begin
    fade_cap = r_now[FW+1:0];
    if (r_now > $signed((MA+MB)'(1) <<< FW)) fade_cap = (FW+2)'(1) << FW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      octave_count <= OctWidth'(8);
      done         <= 1'b0;
      step         <= '0;
      oct          <= '0;
      acc          <= '0;
    end else begin
      // result strobe is registered from the output state, high in the cycle after it
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) octave_count <= cfg_data;
          if (start && operation == OP_SAMPLE) begin
            cx    <= XW'(x_coord);
            cy    <= XW'(y_coord);
            cz    <= XW'(z_coord);
            noct  <= (int'(octave_count) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                         : OW'(octave_count);
            oct   <= '0;
            acc   <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (oct == noct) begin
            state <= S_OUT;
          end else begin
            lx    <= cx[FW+CW-1:FW];
            ly    <= cy[FW+CW-1:FW];
            lz    <= cz[FW+CW-1:FW];
            fx    <= frac_of(cx);
            fy    <= frac_of(cy);
            fz    <= frac_of(cz);
            fsel  <= 2'd0;
            step  <= '0;
            state <= S_FADE;
          end
        end
        S_FADE: begin
          step <= (step[2:0] == 3'd7) ? '0 : step + 5'd1;
          case (step[2:0])
            3'd1: f2 <= r_now[FW+1:0];
            3'd3: f3 <= r_now[FW+1:0];
            3'd5: pp <= (FW+4)'(r_now + ($signed((MA+MB)'(10)) <<< FW));
            3'd7: begin
              case (fsel)
                2'd0: fu <= fade_cap[FW:0];
                2'd1: fv <= fade_cap[FW:0];
                default: fw <= fade_cap[FW:0];
              endcase
              if (fsel == 2'd2) state <= S_HASH;
              fsel <= fsel + 2'd1;
            end
            default: ;
          endcase
        end
        S_HASH: begin
          step <= step + 5'd1;
          case (step)
            5'd1:  ha  <= AW'(t_rdata) + AW'(ly);
            5'd2:  hb  <= AW'(t_rdata) + AW'(ly);
            5'd3:  haa <= AW'(t_rdata) + AW'(lz);
            5'd4:  hab <= AW'(t_rdata) + AW'(lz);
            5'd5:  hba <= AW'(t_rdata) + AW'(lz);
            5'd6:  hbb <= AW'(t_rdata) + AW'(lz);
            5'd7:  hash[0] <= t_rdata[3:0];
            5'd8:  hash[1] <= t_rdata[3:0];
            5'd9:  hash[2] <= t_rdata[3:0];
            5'd10: hash[3] <= t_rdata[3:0];
            5'd11: hash[4] <= t_rdata[3:0];
            5'd12: hash[5] <= t_rdata[3:0];
            5'd13: hash[6] <= t_rdata[3:0];
            5'd14: hash[7] <= t_rdata[3:0];
            5'd15: begin
              gv[0] <= grad(hash[0], dx0, dy0, dz0);
              gv[1] <= grad(hash[1], dx1, dy0, dz0);
              gv[2] <= grad(hash[2], dx0, dy1, dz0);
              gv[3] <= grad(hash[3], dx1, dy1, dz0);
              gv[4] <= grad(hash[4], dx0, dy0, dz1);
              gv[5] <= grad(hash[5], dx1, dy0, dz1);
              gv[6] <= grad(hash[6], dx0, dy1, dz1);
              gv[7] <= grad(hash[7], dx1, dy1, dz1);
              li    <= 3'd0;
              lph   <= 2'd0;
              state <= S_LERP;
            end
            default: ;
          endcase
        end
        S_LERP: begin
          if (lph == 2'd0) begin
            lph <= 2'd1;
          end else begin
            lph <= 2'd0;
            lv[li] <= la + VW'(r_now);
            if (li == 3'd6) state <= S_ACC;
            li <= li + 3'd1;
          end
        end
        S_ACC: begin
          acc   <= acc + add_term;
          oct   <= oct + OW'(1);
          cx    <= cx <<< 1;
          cy    <= cy <<< 1;
          cz    <= cz <<< 1;
          state <= S_SETUP;
        end
        S_OUT: begin
          noise_sum    <= sat(os);
          noise_mapped <= sat(om);
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/opns_checker.sv
`include "octave_perlin_noise_sampler_core_defines.svh"
module opns_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic done
);
  // a result is only shown while the block is idle
  `OPN_ASSERT_IMPL(a_done_busy, clk, rst, done, !busy)
  // a sample request makes the block busy next cycle
  `OPN_ASSERT_NEXT(a_sample_busy, clk, rst, start && !busy && operation, busy)
  // a load request leaves the block idle
  `OPN_ASSERT_NEXT(a_load_idle, clk, rst, start && !busy && !operation, !busy && !done)
  // config is only taken while idle
  `OPN_ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_valid && cfg_ready, !busy)
endmodule

bind octave_perlin_noise_sampler_core opns_checker u_opns_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation[0]),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .done(done)
);
